>>> rtl/wildcard_pattern_match_macros.svh
// Assertion macros for the wildcard pattern matcher checker.
`ifndef WILDCARD_PATTERN_MATCH_MACROS_SVH
`define WILDCARD_PATTERN_MATCH_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define WPM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define WPM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/wpm_pkg.sv
// Types and constants shared by the wildcard pattern matcher modules.
package wpm_pkg;

  localparam int MAX_PATTERN   = 64;
  localparam int ALPHABET_SIZE = 26;
  localparam int POSITION_BITS = 20;
  localparam int SYMBOL_W      = 5;
  localparam int LEN_W         = $clog2(MAX_PATTERN + 1);

  // Letter counter stops at 2^POSITION_BITS + MAX_PATTERN
  localparam logic [63:0] COUNT_CAP = (64'd1 << POSITION_BITS) + 64'(MAX_PATTERN);
  localparam logic [63:0] POS_MAX   = (64'd1 << POSITION_BITS) - 64'd1;
  localparam int          COUNT_W   = $clog2(COUNT_CAP + 64'd1);

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TEXT = 1'b1
  } op_t;

  typedef struct packed {
    op_t                 operation;
    logic [SYMBOL_W-1:0] symbol;
    logic                last;
  } in_item_t;

  typedef struct packed {
    logic [POSITION_BITS-1:0] start_position;
    logic                     matched;
    logic                     position_saturated;
  } out_item_t;

  // What one cell hands to its neighbors
  typedef struct packed {
    logic                active;
    logic [SYMBOL_W-1:0] symbol;
    logic                partial;
  } link_t;

  typedef struct packed {
    logic shift;
    logic step;
  } cell_ctrl_t;

  typedef struct packed {
    logic clear;
    logic step;
    logic last;
  } pos_ctrl_t;

  // Any code at or above the alphabet size is a wildcard in the pattern
  function automatic logic is_wild(input logic [SYMBOL_W-1:0] sym);
    return int'(sym) >= ALPHABET_SIZE;
  endfunction

endpackage

>>> rtl/wildcard_pattern_match.sv
// A result is valid in the cycle after the transfer of the text letter that ends its window.
// Throughput: one item per cycle, pattern symbol or text letter, unless a held result stalls it.
// Partial matches advance one cell per letter through MAX_PATTERN cells; the compare is systolic.
// A held result waits in the output register; a new item is taken only as the result is taken.
// Reset (rst, sync): clears length, complete flag, cell active/partial flags, counter, result_valid.
// Stored pattern symbols are not cleared; only cells inside the loaded length are ever compared.
module wildcard_pattern_match (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  wpm_pkg::in_item_t  item,
  output logic               result_valid,
  input  logic               result_ready,
  output wpm_pkg::out_item_t result
);
  import wpm_pkg::*;

  logic                     accept;
  logic                     is_load;
  logic                     restart;
  logic                     text_step;
  logic [LEN_W-1:0]         pattern_length;
  logic                     pattern_complete;
  logic                     full;
  logic [POSITION_BITS-1:0] start_next;
  logic                     sat_next;
  logic [POSITION_BITS-1:0] start_position;
  logic                     position_saturated;
  cell_ctrl_t               cell_ctrl;
  pos_ctrl_t                pos_ctrl;
  link_t                    links [MAX_PATTERN];

  // Decode the accepted transfer
  always_comb begin
    item_ready      = !result_valid || result_ready;
    accept          = item_valid && item_ready;
    is_load         = accept && (item.operation == OP_LOAD);
    restart         = is_load && pattern_complete;
    text_step       = accept && (item.operation == OP_TEXT) && pattern_complete;
    cell_ctrl.shift = is_load && (restart || (pattern_length < LEN_W'(MAX_PATTERN)));
    cell_ctrl.step  = text_step;
    pos_ctrl.clear  = restart;
    pos_ctrl.step   = text_step;
    pos_ctrl.last   = item.last;
  end

  // Track pattern length and completion
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length   <= '0;
      pattern_complete <= 1'b0;
    end else if (is_load) begin
      pattern_complete <= item.last;
      if (restart) begin
        pattern_length <= LEN_W'(1);
      end else if (cell_ctrl.shift) begin
        pattern_length <= pattern_length + LEN_W'(1);
      end
    end
  end

  // Chain of compare cells; cell 0 holds the newest pattern symbol
  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
    link_t below;
    link_t above;

    if (j == 0) begin : g_bottom
      assign below = '{active: 1'b1, symbol: item.symbol, partial: 1'b0};
    end else begin : g_inner
      assign below = '{active: links[j-1].active & ~restart,
                       symbol: links[j-1].symbol, partial: 1'b0};
    end

    if (j == MAX_PATTERN - 1) begin : g_top
      assign above = '{active: 1'b0, symbol: '0, partial: 1'b1};
    end else begin : g_mid
      assign above = links[j+1];
    end

    wpm_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .ctrl   (cell_ctrl),
      .letter (item.symbol),
      .below  (below),
      .above  (above),
      .state  (links[j])
    );
  end

  wpm_pos u_pos (
    .clk            (clk),
    .rst            (rst),
    .ctrl           (pos_ctrl),
    .pattern_length (pattern_length),
    .full           (full),
    .start_position (start_next),
    .saturated      (sat_next)
  );

  // Output register: load a result on a full-window letter, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (item_ready) begin
      result_valid <= text_step && full;
    end
  end

  always_ff @(posedge clk) begin
    if (text_step) begin
      start_position     <= start_next;
      position_saturated <= sat_next;
    end
  end

  // Cell 0 flag changes only on text steps, so it stays with the held result
  assign result = '{start_position: start_position, matched: links[0].partial,
                    position_saturated: position_saturated};

endmodule

>>> rtl/wpm_cell.sv
// One cell of the matcher chain: a pattern symbol and a partial-match flag.
module wpm_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  wpm_pkg::cell_ctrl_t          ctrl,
  input  logic [wpm_pkg::SYMBOL_W-1:0] letter,
  input  wpm_pkg::link_t               below,
  input  wpm_pkg::link_t               above,
  output wpm_pkg::link_t               state
);
  import wpm_pkg::*;

  logic                active;
  logic [SYMBOL_W-1:0] symbol;
  logic                partial;
  logic                carry;
  logic                partial_next;

  // Extend the match handed down from the cell above; the top of the pattern starts fresh
  always_comb begin
    carry        = above.active ? above.partial : 1'b1;
    partial_next = carry && (is_wild(symbol) || (symbol == letter));
  end

  // Hold the active flag and partial match
  always_ff @(posedge clk) begin
    if (rst) begin
      active  <= 1'b0;
      partial <= 1'b0;
    end else begin
      if (ctrl.shift) begin
        active <= below.active;
      end
      if (ctrl.step) begin
        partial <= partial_next;
      end
    end
  end

  // Advance the pattern symbol up the chain on a load
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      symbol <= below.symbol;
    end
  end

  assign state = '{active: active, symbol: symbol, partial: partial};

endmodule

>>> rtl/wpm_pos.sv
// Text letter counter and window start position with saturation.
module wpm_pos (
  input  logic                              clk,
  input  logic                              rst,
  input  wpm_pkg::pos_ctrl_t                ctrl,
  input  logic [wpm_pkg::LEN_W-1:0]         pattern_length,
  output logic                              full,
  output logic [wpm_pkg::POSITION_BITS-1:0] start_position,
  output logic                              saturated
);
  import wpm_pkg::*;

  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_next;
  logic [COUNT_W-1:0] start_raw;

  // Count this letter, then locate the window start
  always_comb begin
    count_next     = (count < COUNT_W'(COUNT_CAP)) ? count + COUNT_W'(1) : count;
    full           = count_next >= COUNT_W'(pattern_length);
    start_raw      = count_next - COUNT_W'(pattern_length);
    saturated      = start_raw > COUNT_W'(POS_MAX);
    start_position = saturated ? POSITION_BITS'(POS_MAX) : start_raw[POSITION_BITS-1:0];
  end

  // Drop the count on a new pattern or at the end of a text
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.clear) begin
      count <= '0;
    end else if (ctrl.step) begin
      count <= ctrl.last ? '0 : count_next;
    end
  end

endmodule

>>> rtl/wpm_checker.sv
// Port-level checks for the wildcard pattern matcher, bound to its top level.
`include "wildcard_pattern_match_macros.svh"

module wpm_checker (
  input logic               clk,
  input logic               rst,
  input logic               item_valid,
  input logic               item_ready,
  input wpm_pkg::in_item_t  item,
  input logic               result_valid,
  input logic               result_ready,
  input wpm_pkg::out_item_t result
);
  import wpm_pkg::*;

  // Hold a stalled result
  `WPM_ASSERT_NEXT(a_result_held, result_valid && !result_ready, result_valid && $stable(result), "result dropped or changed while stalled")

  // A fresh result follows a text letter transfer
  `WPM_ASSERT_NOW(a_result_source, result_valid && !$past(result_valid && !result_ready), $past(item_valid && item_ready && (item.operation == OP_TEXT)), "result without a text letter transfer")

  // A pattern symbol transfer produces no result
  `WPM_ASSERT_NEXT(a_load_silent, item_valid && item_ready && (item.operation == OP_LOAD), !result_valid, "result after a pattern symbol transfer")

  // A saturated position reads all ones
  `WPM_ASSERT_NOW(a_sat_value, result_valid && result.position_saturated, &result.start_position, "saturated position not at its maximum")

endmodule

bind wildcard_pattern_match wpm_checker u_checker (.*);
